// ===== src/msp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_pkg
// Types and constants shared by the shortest path cells and the top level.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned CostW    = 16;
  localparam int unsigned TimeW    = 24;

  localparam logic [TimeW-1:0] TimeAll = {TimeW{1'b1}};
  localparam logic [TimeW-1:0] TimeTop = {{(TimeW-1){1'b1}}, 1'b0};

  typedef enum logic [2:0] {
    OP_SET_COST = 3'd0,
    OP_ADD_EDGE = 3'd1,
    OP_MARK_SRC = 3'd2,
    OP_RUN      = 3'd3,
    OP_READ     = 3'd4,
    OP_CLEAR    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CELL_NONE,
    CELL_SET_COST,
    CELL_ADD_EDGE,
    CELL_MARK_SRC,
    CELL_CLEAR,
    CELL_INIT,
    CELL_RELAX
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_SEARCH,
    S_RESULT
  } state_e;

  typedef struct packed {
    cell_op_e          op;
    logic [IdxW-1:0]   node;
    logic [IdxW-1:0]   other;
    logic [CostW-1:0]  cost;
    logic [IdxW-1:0]   pick;
    logic [TimeW-1:0]  least;
    logic [CntW-1:0]   count;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [IdxW-1:0]   pick;
    logic [TimeW-1:0]  least;
    logic [TimeW-1:0]  most;
    logic              missing;
  } token_t;

endpackage

// ===== src/msp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_in_if / msp_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface msp_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    op;
  logic [msp_pkg::IdxW-1:0]      node;
  logic [msp_pkg::IdxW-1:0]      other_node;
  logic [msp_pkg::CostW-1:0]     cost;

  modport source (output valid, op, node, other_node, cost, input ready);
  modport sink (input valid, op, node, other_node, cost, output ready);
endinterface

interface msp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [msp_pkg::TimeW-1:0]     arrival_time;
  logic                          unreached;

  modport source (output valid, kind, arrival_time, unreached, input ready);
  modport sink (input valid, kind, arrival_time, unreached, output ready);
endinterface

// ===== src/multi_source_node_weighted_shortest_path_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_source_node_weighted_shortest_path_unit
// Multi-source shortest path over node costs, built as a chain of node cells.
// ----------------------------------------------------------------------------
// Load, clear and read items are each done without leaving the idle state. A
// run item settles one node per round; each round launches a search token and
// sends it down the 64-cell chain, one cell a cycle. The result beat of a run
// is issued from the result state once the output slot is free. The last
// token pass also gathers the maximum time that the run reports.
// ----------------------------------------------------------------------------
module multi_source_node_weighted_shortest_path_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  msp_in_if.sink      in_i,
  msp_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  msp_pkg::state_e              state_q, state_d;
  logic [msp_pkg::CntW-1:0]     count_q;
  msp_pkg::cmd_t                cmd;
  msp_pkg::token_t              tok [msp_pkg::MaxNodes+1];
  logic [msp_pkg::TimeW-1:0]    best_w [msp_pkg::MaxNodes];
  logic                         out_valid_q, out_valid_d;
  logic                         kind_q, kind_d;
  logic [msp_pkg::TimeW-1:0]    time_q, time_d;
  logic                         unr_q, unr_d;
  logic                         slot_free, accept;
  logic                         node_ok, other_ok;
  logic [6:0]                   wval;

  assign pready = 1'b1;
  assign prdata = {{(32-msp_pkg::CntW){1'b0}}, count_q};
  assign wval   = pwdata[6:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= msp_pkg::CntW'(msp_pkg::MaxNodes);
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      if (wval == 7'd0) begin
        count_q <= msp_pkg::CntW'(1);
      end else if (wval > 7'(msp_pkg::MaxNodes)) begin
        count_q <= msp_pkg::CntW'(msp_pkg::MaxNodes);
      end else begin
        count_q <= wval;
      end
    end
  end

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == msp_pkg::S_IDLE) && slot_free;
  assign accept     = in_i.valid && in_i.ready;
  assign node_ok    = {1'b0, in_i.node} < count_q;
  assign other_ok   = {1'b0, in_i.other_node} < count_q;

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = (state_q == msp_pkg::S_LAUNCH);
    tok[0].least = msp_pkg::TimeAll;
  end

  for (genvar g = 0; g < msp_pkg::MaxNodes; g++) begin : g_cell
    msp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (msp_pkg::IdxW'(g)),
      .cmd_i  (cmd),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1]),
      .best_o (best_w[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    kind_d      = kind_q;
    time_d      = time_q;
    unr_d       = unr_q;
    cmd         = '0;
    cmd.op      = msp_pkg::CELL_NONE;
    cmd.node    = in_i.node;
    cmd.other   = in_i.other_node;
    cmd.cost    = in_i.cost;
    cmd.pick    = tok[msp_pkg::MaxNodes].pick;
    cmd.least   = tok[msp_pkg::MaxNodes].least;
    cmd.count   = count_q;
    case (state_q)
      msp_pkg::S_IDLE: begin
        if (accept) begin
          case (in_i.op)
            msp_pkg::OP_SET_COST: if (node_ok) cmd.op = msp_pkg::CELL_SET_COST;
            msp_pkg::OP_ADD_EDGE: if (node_ok && other_ok) cmd.op = msp_pkg::CELL_ADD_EDGE;
            msp_pkg::OP_MARK_SRC: if (node_ok) cmd.op = msp_pkg::CELL_MARK_SRC;
            msp_pkg::OP_CLEAR:    cmd.op = msp_pkg::CELL_CLEAR;
            msp_pkg::OP_RUN: begin
              cmd.op  = msp_pkg::CELL_INIT;
              state_d = msp_pkg::S_LAUNCH;
            end
            msp_pkg::OP_READ: begin
              if (node_ok) begin
                out_valid_d = 1'b1;
                kind_d      = 1'b0;
                time_d      = best_w[in_i.node];
                unr_d       = (best_w[in_i.node] == msp_pkg::TimeAll);
              end
            end
            default: ;
          endcase
        end
      end
      msp_pkg::S_LAUNCH: state_d = msp_pkg::S_SEARCH;
      msp_pkg::S_SEARCH: begin
        if (tok[msp_pkg::MaxNodes].valid) begin
          if (tok[msp_pkg::MaxNodes].found) begin
            cmd.op  = msp_pkg::CELL_RELAX;
            state_d = msp_pkg::S_LAUNCH;
          end else begin
            kind_d  = 1'b1;
            unr_d   = tok[msp_pkg::MaxNodes].missing;
            time_d  = tok[msp_pkg::MaxNodes].missing ? msp_pkg::TimeAll
                                                     : tok[msp_pkg::MaxNodes].most;
            state_d = msp_pkg::S_RESULT;
          end
        end
      end
      msp_pkg::S_RESULT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = msp_pkg::S_IDLE;
        end
      end
      default: state_d = msp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    time_q <= time_d;
    unr_q  <= unr_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = kind_q;
  assign out_o.arrival_time = time_q;
  assign out_o.unreached    = unr_q;

endmodule

// ===== src/msp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_cell
// One graph node: its cost, source mark, adjacency row, time and settled flag.
// A search token passes through its register and picks up the least unsettled time.
// ----------------------------------------------------------------------------
module msp_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [msp_pkg::IdxW-1:0]   idx_i,
  input  msp_pkg::cmd_t              cmd_i,
  input  msp_pkg::token_t            tok_i,
  output msp_pkg::token_t            tok_o,
  output logic [msp_pkg::TimeW-1:0]  best_o
);

  logic [msp_pkg::MaxNodes-1:0] adj_q, adj_d;
  logic [msp_pkg::CostW-1:0]    cost_q, cost_d;
  logic                         src_q, src_d;
  logic [msp_pkg::TimeW-1:0]    best_q, best_d;
  logic                         set_q, set_d;
  msp_pkg::token_t              tok_q, tok_d;
  logic                         in_use;
  logic [msp_pkg::TimeW:0]      sum;
  logic [msp_pkg::TimeW-1:0]    cand;

  assign in_use = {1'b0, idx_i} < cmd_i.count;
  assign sum    = {1'b0, cmd_i.least} + {{(msp_pkg::TimeW+1-msp_pkg::CostW){1'b0}}, cost_q};
  assign cand   = (sum > {1'b0, msp_pkg::TimeTop}) ? msp_pkg::TimeTop
                                                    : sum[msp_pkg::TimeW-1:0];

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && in_use) begin
      if (!set_q && best_q < tok_i.least) begin
        tok_d.least = best_q;
        tok_d.pick  = idx_i;
        tok_d.found = 1'b1;
      end
      if (best_q == msp_pkg::TimeAll) begin
        tok_d.missing = 1'b1;
      end else if (best_q > tok_i.most) begin
        tok_d.most = best_q;
      end
    end
  end

  always_comb begin
    adj_d  = adj_q;
    cost_d = cost_q;
    src_d  = src_q;
    best_d = best_q;
    set_d  = set_q;
    case (cmd_i.op)
      msp_pkg::CELL_SET_COST: begin
        if (cmd_i.node == idx_i) cost_d = cmd_i.cost;
      end
      msp_pkg::CELL_ADD_EDGE: begin
        if (cmd_i.node == idx_i) adj_d[cmd_i.other] = 1'b1;
        if (cmd_i.other == idx_i) adj_d[cmd_i.node] = 1'b1;
      end
      msp_pkg::CELL_MARK_SRC: begin
        if (cmd_i.node == idx_i) src_d = 1'b1;
      end
      msp_pkg::CELL_CLEAR: begin
        adj_d  = '0;
        cost_d = '0;
        src_d  = 1'b0;
        best_d = msp_pkg::TimeAll;
        set_d  = 1'b0;
      end
      msp_pkg::CELL_INIT: begin
        set_d  = 1'b0;
        best_d = (src_q && in_use)
                 ? {{(msp_pkg::TimeW-msp_pkg::CostW){1'b0}}, cost_q}
                 : msp_pkg::TimeAll;
      end
      msp_pkg::CELL_RELAX: begin
        if (cmd_i.pick == idx_i) begin
          set_d = 1'b1;
        end else if (in_use && !set_q && adj_q[cmd_i.pick] && cand < best_q) begin
          best_d = cand;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q  <= '0;
      cost_q <= '0;
      src_q  <= 1'b0;
      best_q <= msp_pkg::TimeAll;
      set_q  <= 1'b0;
      tok_q  <= '0;
    end else begin
      adj_q  <= adj_d;
      cost_q <= cost_d;
      src_q  <= src_d;
      best_q <= best_d;
      set_q  <= set_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o  = tok_q;
  assign best_o = best_q;

endmodule
